>>> hdl/cnd_pkg.sv
// Shared types and constants for the crop and nearest-neighbor downscaler.
package cnd_pkg;

    localparam int CFG_W         = 11;
    localparam int CFG_AW        = 3;
    localparam int PIX_W         = 8;
    localparam int TDATA_W       = 8;
    localparam int MAX_DIM_DEF   = 1024;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QDEPTH        = 4;

    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CROP_WIDTH   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_CROP_HEIGHT  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_OUT_WIDTH    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_OUT_HEIGHT   = 3'd5;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd64;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd64;
    localparam logic [CFG_W-1:0] RST_CROP_WIDTH   = 11'd64;
    localparam logic [CFG_W-1:0] RST_CROP_HEIGHT  = 11'd64;
    localparam logic [CFG_W-1:0] RST_OUT_WIDTH    = 11'd32;
    localparam logic [CFG_W-1:0] RST_OUT_HEIGHT   = 11'd32;

    typedef struct packed {
        logic              last;
        logic [PIX_W-1:0]  pixel;
    } t_result;

endpackage

>>> hdl/cnd_div.sv
// Restoring divider, one quotient bit per cycle, for the 11.16 scale steps.
module cnd_div #(
    parameter int DW = 11,
    parameter int PW = 27
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic [PW-1:0] o_quot
);
    localparam int CNTW = $clog2(PW + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_div;
    logic [DW-1:0]   r_rem;
    logic [PW-1:0]   r_q;
    logic [DW:0]     w_sh;
    logic            w_ge;
    logic [DW:0]     w_diff;

    assign w_sh   = {r_rem, r_q[PW-1]};
    assign w_ge   = w_sh >= {1'b0, r_div};
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(PW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_q   <= {r_q[PW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && r_cnt == CNTW'(PW))
        else $error("divider did not start");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0)
        else $error("divider count left over when idle");

endmodule

>>> hdl/cnd_front.sv
// Front end: raster position tracking, crop and sample selection per pixel.
module cnd_front #(
    parameter int MAX_DIM   = cnd_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = cnd_pkg::FRAC_BITS_DEF,
    parameter int DW        = $clog2(MAX_DIM + 1),
    parameter int PW        = DW + FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [cnd_pkg::PIX_W-1:0] i_pixel,
    output logic                      o_ready,
    input  logic                      i_block,
    input  logic                      i_full,
    input  logic [DW-1:0]             i_iw,
    input  logic [DW-1:0]             i_ih,
    input  logic [DW-1:0]             i_cw,
    input  logic [DW-1:0]             i_ch,
    input  logic [DW-1:0]             i_ow,
    input  logic [DW-1:0]             i_oh,
    input  logic [PW-1:0]             i_col_step,
    input  logic [PW-1:0]             i_row_step,
    output logic                      o_push,
    output cnd_pkg::t_result          o_result
);
    import cnd_pkg::*;

    localparam int SCW = $clog2(MAX_DIM);

    logic [SCW-1:0] r_src_col, r_src_row, n_src_col, n_src_row;
    logic [DW-1:0]  r_out_col, r_out_row, n_out_col, n_out_row;
    logic [PW-1:0]  r_pos_c, r_pos_r, n_pos_c, n_pos_r;
    logic [PW-1:0]  r_col_step, r_row_step, n_col_step, n_row_step;
    logic           w_accept, w_first, w_row_hit, w_hit, w_col_end, w_row_end;
    logic [PW-1:0]  w_cstep, w_rstep;

    assign o_ready  = !i_block && !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_first  = r_src_col == '0 && r_src_row == '0;
    assign w_cstep  = w_first ? i_col_step : r_col_step;
    assign w_rstep  = w_first ? i_row_step : r_row_step;

    assign w_row_hit = DW'(r_src_row) < i_ch && r_out_row < i_oh
                    && DW'(r_src_row) == r_pos_r[PW-1:FRAC_BITS];
    assign w_hit     = w_row_hit && DW'(r_src_col) < i_cw && r_out_col < i_ow
                    && DW'(r_src_col) == r_pos_c[PW-1:FRAC_BITS];
    assign w_col_end = DW'(r_src_col) >= i_iw - 1'b1;
    assign w_row_end = DW'(r_src_row) >= i_ih - 1'b1;

    assign o_push          = w_accept && w_hit;
    assign o_result.pixel  = i_pixel;
    assign o_result.last   = r_out_col == i_ow - 1'b1 && r_out_row == i_oh - 1'b1;

    always_comb begin
        n_src_col  = r_src_col;
        n_src_row  = r_src_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_pos_c    = r_pos_c;
        n_pos_r    = r_pos_r;
        n_col_step = w_cstep;
        n_row_step = w_rstep;
        if (w_hit) begin
            n_out_col = r_out_col + 1'b1;
            n_pos_c   = r_pos_c + w_cstep;
        end
        if (w_col_end) begin
            if (w_row_end) begin
                n_src_col  = '0;
                n_src_row  = '0;
                n_out_col  = '0;
                n_out_row  = '0;
                n_pos_c    = '0;
                n_pos_r    = '0;
                n_col_step = '0;
                n_row_step = '0;
            end else begin
                if (w_row_hit) begin
                    n_out_row = r_out_row + 1'b1;
                    n_pos_r   = r_pos_r + w_rstep;
                end
                n_out_col = '0;
                n_pos_c   = '0;
                n_src_col = '0;
                n_src_row = r_src_row + 1'b1;
            end
        end else begin
            n_src_col = r_src_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_pos_c    <= '0;
            r_pos_r    <= '0;
            r_col_step <= '0;
            r_row_step <= '0;
        end else if (w_accept) begin
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_pos_c    <= n_pos_c;
            r_pos_r    <= n_pos_r;
            r_col_step <= n_col_step;
            r_row_step <= n_row_step;
        end
    end

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_col_end && w_row_end |=> r_src_col == '0 && r_src_row == '0
            && r_out_row == '0 && r_pos_r == '0)
        else $error("frame end did not return to start");
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_col_end |=> r_out_col == '0 && r_pos_c == '0)
        else $error("row end did not clear column position");

endmodule

>>> hdl/cnd_queue.sv
// Back end: short result queue that drives the output stream.
module cnd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cnd_pkg::t_result  i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output cnd_pkg::t_result  o_result
);
    import cnd_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    t_result        r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic           w_pop;

    assign o_full   = r_count == QCW'(QDEPTH);
    assign o_valid  = r_count != '0;
    assign w_pop    = o_valid && i_ready;
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("queue count out of range");

endmodule

>>> hdl/crop_nearest_downscale_top.sv
// Top level of the crop and nearest-neighbor downscaler.
// Takes one full-image pixel per clock in raster order and emits the nearest-neighbor
// downscaled copy of the top-left crop window; each result is pushed into a 4-entry
// queue as its source pixel is transferred, with tlast on the final output pixel.
// The 11.16 column and row steps (default parameters) come from two restoring dividers
// that produce one quotient bit per cycle: after reset and after every configuration
// write, input is held off while the steps are recomputed; otherwise input is taken
// every cycle unless the output queue is full.
module crop_nearest_downscale_top #(
    parameter int MAX_DIM   = cnd_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = cnd_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [cnd_pkg::TDATA_W-1:0] i_s_tdata,   // [7:0] pixel_in
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [cnd_pkg::TDATA_W-1:0] o_m_tdata,   // [7:0] pixel_out
    output logic                        o_m_tlast,   // last_pixel
    input  logic                        i_cfg_we,
    input  logic [cnd_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [cnd_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import cnd_pkg::*;

    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int PW   = DW + FRAC_BITS;
    localparam int CMPW = (DW > CFG_W) ? DW : CFG_W;

    logic [CFG_W-1:0] r_image_width, r_image_height, r_crop_width, r_crop_height;
    logic [CFG_W-1:0] r_out_width, r_out_height;
    logic             r_div_start;
    logic [DW-1:0]    w_iw, w_ih, w_cw, w_ch, w_ow, w_oh;
    logic [PW-1:0]    w_col_step, w_row_step;
    logic             w_col_busy, w_row_busy, w_block, w_full, w_push;
    t_result          w_push_result, w_out_result;

    function automatic logic [DW-1:0] clampv(input logic [CFG_W-1:0] v,
                                             input logic [DW-1:0] hi);
        logic [CMPW-1:0] ve;
        logic [CMPW-1:0] he;
        ve = CMPW'(v);
        he = CMPW'(hi);
        if (ve == '0) begin
            return DW'(1);
        end else if (ve > he) begin
            return hi;
        end else begin
            return DW'(ve);
        end
    endfunction

    assign w_iw = clampv(r_image_width, DW'(MAX_DIM));
    assign w_ih = clampv(r_image_height, DW'(MAX_DIM));
    assign w_cw = clampv(r_crop_width, w_iw);
    assign w_ch = clampv(r_crop_height, w_ih);
    assign w_ow = clampv(r_out_width, w_cw);
    assign w_oh = clampv(r_out_height, w_ch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_crop_width   <= RST_CROP_WIDTH;
            r_crop_height  <= RST_CROP_HEIGHT;
            r_out_width    <= RST_OUT_WIDTH;
            r_out_height   <= RST_OUT_HEIGHT;
            r_div_start    <= 1'b1;
        end else begin
            r_div_start <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                    REG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                    REG_CROP_WIDTH:   r_crop_width   <= i_cfg_wdata;
                    REG_CROP_HEIGHT:  r_crop_height  <= i_cfg_wdata;
                    REG_OUT_WIDTH:    r_out_width    <= i_cfg_wdata;
                    REG_OUT_HEIGHT:   r_out_height   <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    cnd_div #(.DW(DW), .PW(PW)) u_col_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend ({w_cw, {FRAC_BITS{1'b0}}}),
        .i_divisor  (w_ow),
        .o_busy     (w_col_busy),
        .o_quot     (w_col_step)
    );

    cnd_div #(.DW(DW), .PW(PW)) u_row_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend ({w_ch, {FRAC_BITS{1'b0}}}),
        .i_divisor  (w_oh),
        .o_busy     (w_row_busy),
        .o_quot     (w_row_step)
    );

    assign w_block = w_col_busy || w_row_busy || r_div_start || i_cfg_we;

    cnd_front #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW),
        .PW        (PW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_pixel    (i_s_tdata[PIX_W-1:0]),
        .o_ready    (o_s_tready),
        .i_block    (w_block),
        .i_full     (w_full),
        .i_iw       (w_iw),
        .i_ih       (w_ih),
        .i_cw       (w_cw),
        .i_ch       (w_ch),
        .i_ow       (w_ow),
        .i_oh       (w_oh),
        .i_col_step (w_col_step),
        .i_row_step (w_row_step),
        .o_push     (w_push),
        .o_result   (w_push_result)
    );

    cnd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_push_result),
        .o_full   (w_full),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_out_result)
    );

    assign o_m_tdata = TDATA_W'(w_out_result.pixel);
    assign o_m_tlast = w_out_result.last;

    a_no_take_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_col_busy || w_row_busy) |-> !(i_s_tvalid && o_s_tready))
        else $error("pixel transfer while steps are being computed");
    a_dividers_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_col_busy == w_row_busy)
        else $error("step dividers out of step");

endmodule

>>> verif/crop_nearest_downscale_top_tb.sv
// Self-checking testbench for the crop and nearest-neighbor downscaler top level.
module crop_nearest_downscale_top_tb;
    import cnd_pkg::*;

    localparam logic [CFG_AW-1:0] REG_UNMAPPED_6 = 3'd6;
    localparam logic [CFG_AW-1:0] REG_UNMAPPED_7 = 3'd7;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_ITEMS   = 400;

    class downscale_scoreboard;
        logic [CFG_W-1:0] img_w, img_h, crop_w, crop_h, out_w, out_h;
        logic [9:0]       src_col, src_row;
        logic [10:0]      out_col, out_row;
        logic [26:0]      col_pos, row_pos, col_step, row_step;
        t_result          expected_q[$];
        int unsigned      mismatches;

        function new();
            img_w  = RST_IMAGE_WIDTH;
            img_h  = RST_IMAGE_HEIGHT;
            crop_w = RST_CROP_WIDTH;
            crop_h = RST_CROP_HEIGHT;
            out_w  = RST_OUT_WIDTH;
            out_h  = RST_OUT_HEIGHT;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            src_col  = '0;
            src_row  = '0;
            out_col  = '0;
            out_row  = '0;
            col_pos  = '0;
            row_pos  = '0;
            col_step = '0;
            row_step = '0;
        endfunction

        static function logic [CFG_W-1:0] sat(logic [CFG_W-1:0] v, logic [CFG_W-1:0] hi);
            if (v == 0) return CFG_W'(1);
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_IMAGE_WIDTH: img_w = val;
                REG_IMAGE_HEIGHT: img_h = val;
                REG_CROP_WIDTH: crop_w = val;
                REG_CROP_HEIGHT: crop_h = val;
                REG_OUT_WIDTH: out_w = val;
                REG_OUT_HEIGHT: out_h = val;
                default: ;
            endcase
        endfunction

        // one full-image pixel transferred in; queue the output pixel it selects, if any
        function void take_pixel(logic [PIX_W-1:0] pix);
            logic [CFG_W-1:0] iw, ih, cw, ch, ow, oh;
            bit               row_hit;
            t_result          r;
            iw = sat(img_w, CFG_W'(MAX_DIM_DEF));
            ih = sat(img_h, CFG_W'(MAX_DIM_DEF));
            cw = sat(crop_w, iw);
            ch = sat(crop_h, ih);
            ow = sat(out_w, cw);
            oh = sat(out_h, ch);
            if (src_col == 0 && src_row == 0) begin
                col_step = 27'((32'(cw) << FRAC_BITS_DEF) / 32'(ow));
                row_step = 27'((32'(ch) << FRAC_BITS_DEF) / 32'(oh));
            end
            row_hit = (src_row < ch) && (out_row < oh) &&
                      (27'(src_row) == (row_pos >> FRAC_BITS_DEF));
            if (row_hit && src_col < cw && out_col < ow &&
                27'(src_col) == (col_pos >> FRAC_BITS_DEF)) begin
                r.pixel = pix;
                r.last  = (out_col == ow - 11'd1) && (out_row == oh - 11'd1);
                expected_q.push_back(r);
                out_col++;
                col_pos += col_step;
            end
            if (32'(src_col) >= 32'(iw) - 1) begin
                if (32'(src_row) >= 32'(ih) - 1) begin
                    clear_frame();
                    return;
                end
                if (row_hit) begin
                    out_row++;
                    row_pos += row_step;
                end
                out_col = '0;
                col_pos = '0;
                src_col = '0;
                src_row++;
            end else begin
                src_col++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            if (mismatches < 10)
                $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
            mismatches++;
        endfunction

        function void check_pixel(logic [PIX_W-1:0] pix, logic last);
            t_result r;
            if (expected_q.size() == 0) begin
                report("unexpected transfer, pixel", 0, pix);
                return;
            end
            r = expected_q.pop_front();
            if (pix !== r.pixel) report("pixel", r.pixel, pix);
            if (last !== r.last) report("tlast", r.last, last);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [TDATA_W-1:0]   i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_tdata;
    logic                 o_m_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    downscale_scoreboard sb = new();

    bit          src_gaps = 1'b0;
    bit          sink_stalls = 1'b0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    crop_nearest_downscale_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // sink backpressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (sink_stalls && $urandom_range(0, 99) < 30) begin
            stall_left = pick_gap();
        end
        i_m_tready <= (stall_left == 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(i_cfg_addr, i_cfg_wdata);
            if (o_m_tvalid && i_m_tready) sb.check_pixel(o_m_tdata[PIX_W-1:0], o_m_tlast);
            if (i_s_tvalid && o_s_tready) sb.take_pixel(i_s_tdata[PIX_W-1:0]);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("[crop_nearest_downscale_top] ERROR");
                $finish;
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = (src_gaps && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= TDATA_W'(pix);
        forever begin
            @(posedge i_clk);
            if (i_s_tvalid && o_s_tready) break;
        end
    endtask

    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_pixels(input int unsigned count, input int pause_at);
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) hold_until_drained();
            send_pixel(PIX_W'($urandom_range(0, 255)));
        end
        i_s_tvalid <= 1'b0;
    endtask

    // block may still be busy on a pixel with no output after the last result
    task automatic wait_idle();
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_cfg(input logic [CFG_W-1:0] iw, ih, cw, ch, ow, oh,
                             input bit with_spare);
        logic [CFG_AW-1:0] idx[8];
        logic [CFG_W-1:0]  val[8];
        int                n;
        idx = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_CROP_WIDTH, REG_CROP_HEIGHT,
                REG_OUT_WIDTH, REG_OUT_HEIGHT, REG_UNMAPPED_6, REG_UNMAPPED_7};
        val = '{iw, ih, cw, ch, ow, oh, 11'h7FF, 11'h7FF};
        n = with_spare ? 8 : 6;
        for (int i = 0; i < n; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx[i];
            i_cfg_wdata <= val[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] iw, ih, cw, ch, ow, oh;
        int unsigned      count, frame_len, random_items;
        int               pause_at;
        bit               long_phase;

        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes, stopped inside row 1 and resized mid-frame
        run_pixels(66, 40);
        wait_idle();
        apply_cfg(11'd5, 11'd4, 11'd5, 11'd4, 11'd3, 11'd2, 1'b0);
        run_pixels(33, -1);
        wait_idle();

        // one-pixel frames, zero sizes and unmapped indexes
        apply_cfg(11'd1, 11'd1, 11'd0, 11'd0, 11'd0, 11'd0, 1'b1);
        sink_stalls = 1'b1;
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hA5);
        send_pixel(8'h5A);
        i_s_tvalid <= 1'b0;
        wait_idle();

        // crop larger than image, output larger than crop
        apply_cfg(11'd6, 11'd3, 11'd50, 11'h7FF, 11'h7FF, 11'd2, 1'b0);
        src_gaps = 1'b1;
        run_pixels(36, 20);
        wait_idle();

        // widest row at unit step, then the top of the tallest column
        apply_cfg(11'h7FF, 11'd0, 11'h7FF, 11'h7FF, 11'h7FF, 11'd0, 1'b0);
        run_pixels(1024, -1);
        wait_idle();
        apply_cfg(11'd0, 11'd1024, 11'd1, 11'd1024, 11'd1, 11'd700, 1'b0);
        run_pixels(100, 50);
        wait_idle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            long_phase = ($urandom_range(0, 11) == 0);
            if (long_phase) begin
                if ($urandom_range(0, 1)) begin
                    iw = CFG_W'($urandom_range(0, 2047));
                    ih = CFG_W'($urandom_range(0, 2));
                end else begin
                    iw = CFG_W'($urandom_range(0, 2));
                    ih = CFG_W'($urandom_range(0, 2047));
                end
                cw = CFG_W'($urandom_range(0, 2047));
                ch = CFG_W'($urandom_range(0, 2047));
                ow = CFG_W'($urandom_range(0, 2047));
                oh = CFG_W'($urandom_range(0, 2047));
            end else begin
                iw = CFG_W'($urandom_range(1, 24));
                ih = CFG_W'($urandom_range(1, 12));
                cw = CFG_W'($urandom_range(0, iw + 2));
                ch = CFG_W'($urandom_range(0, ih + 2));
                ow = CFG_W'($urandom_range(0, cw + 2));
                oh = CFG_W'($urandom_range(0, ch + 2));
            end
            apply_cfg(iw, ih, cw, ch, ow, oh, $urandom_range(0, 9) == 0);
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            frame_len = int'(sb.sat(iw, CFG_W'(MAX_DIM_DEF))) *
                        int'(sb.sat(ih, CFG_W'(MAX_DIM_DEF)));
            count = long_phase ? frame_len : frame_len * $urandom_range(1, 3);
            // leave a frame unfinished so the next sizes land mid-frame
            if ($urandom_range(0, 4) == 0) count += $urandom_range(1, frame_len);
            if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
            pause_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, count - 1)) : -1;
            run_pixels(count, pause_at);
            random_items += count;
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[crop_nearest_downscale_top] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
            $display("[crop_nearest_downscale_top] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/cnd_pkg.sv
hdl/cnd_div.sv
hdl/cnd_front.sv
hdl/cnd_queue.sv
hdl/crop_nearest_downscale_top.sv
verif/crop_nearest_downscale_top_tb.sv
